>>> sv/assert_macros.svh
// Assertion macros used by the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising aclk edge outside reset.
`define ASSERT_AT_CLK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Expression must never be true at a rising aclk edge outside reset.
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> sv/sitr_pkg.sv
// Package with types and constants of the signed integer to radix text block.
package sitr_pkg;

    localparam int NUM_SYMS    = 16;
    localparam int MAX_DIGITS  = 32;
    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int DADDR_W     = 5;
    localparam int DCNT_W      = 6;
    localparam int RADIX_W     = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [7:0] PLUS_CODE  = 8'd43;
    localparam logic [7:0] MINUS_CODE = 8'd45;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA_LEN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMS_FIRST = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMS_LAST  = 2'd2;

    typedef logic [NUM_SYMS-1:0][7:0] sitr_syms_t;

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } div_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_READ,
        EM_SHOW
    } emit_state_t;

    // digit traffic from the divider to the character emitter
    typedef struct packed {
        logic               wr_en;
        logic [DADDR_W-1:0] addr;
        logic [DIGIT_W-1:0] digit;
        logic               done;
        logic [DCNT_W-1:0]  count;
    } sitr_dig_wr_t;

endpackage

>>> sv/sitr_cfg.sv
// Configuration registers and registered alphabet validity check.
module sitr_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [sitr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [sitr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [sitr_pkg::RADIX_W-1:0]         radix,
    output sitr_pkg::sitr_syms_t                 syms,
    output logic                                 alpha_ok,
    output logic                                 busy
);
    import sitr_pkg::*;

    logic [RADIX_W-1:0]    len_reg;
    logic [CFG_DATA_W-1:0] first_reg;
    logic [CFG_DATA_W-1:0] last_reg;
    logic                  ok_reg, ok_next;
    logic                  pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            ok_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            ok_reg   <= ok_next;
            pend_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_ALPHA_LEN:  len_reg   <= cfg_wdata[RADIX_W-1:0];
                    CFG_SYMS_FIRST: first_reg <= cfg_wdata;
                    CFG_SYMS_LAST:  last_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign syms = sitr_syms_t'({last_reg, first_reg});

    // length range, sign-code and pairwise compare of all symbols in use; result is registered
    always_comb begin
        ok_next = (len_reg >= RADIX_W'(2)) && (len_reg <= RADIX_W'(NUM_SYMS));
        for (int i = 0; i < NUM_SYMS; i++) begin
            if (RADIX_W'(i) < len_reg) begin
                if (syms[i] == PLUS_CODE || syms[i] == MINUS_CODE) begin
                    ok_next = 1'b0;
                end
                for (int j = i + 1; j < NUM_SYMS; j++) begin
                    if (RADIX_W'(j) < len_reg && syms[i] == syms[j]) begin
                        ok_next = 1'b0;
                    end
                end
            end
        end
    end

    assign radix    = len_reg;
    assign alpha_ok = ok_reg;
    // validity settles in the cycle after a register write
    assign busy     = pend_reg;

endmodule

>>> sv/sitr_div.sv
// Bit-serial restoring divider that peels off digits, least significant first.
module sitr_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [sitr_pkg::VALUE_W-1:0]      magnitude,
    input  logic [sitr_pkg::RADIX_W-1:0]      radix,
    output logic                              busy,
    output sitr_pkg::sitr_dig_wr_t            dig_wr
);
    import sitr_pkg::*;

    div_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]  quo_reg, quo_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [DADDR_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DCNT_W-1:0]   dig_cnt_reg, dig_cnt_next;

    logic [RADIX_W-1:0]  trial;
    logic                ge;
    logic [DIGIT_W-1:0]  new_rem;
    logic [VALUE_W-1:0]  quo_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= DV_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // one quotient bit per cycle; remainder stays below the radix
    assign trial     = {rem_reg, quo_reg[VALUE_W-1]};
    assign ge        = trial >= radix;
    assign new_rem   = ge ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
    assign quo_shift = {quo_reg[VALUE_W-2:0], ge};

    always_comb begin
        state_next   = state_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        dig_wr       = '0;
        dig_wr.addr  = dig_cnt_reg[DADDR_W-1:0];
        dig_wr.digit = new_rem;
        dig_wr.count = DCNT_W'(dig_cnt_reg + DCNT_W'(1));

        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    quo_next     = magnitude;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = '0;
                    state_next   = DV_RUN;
                end
            end
            DV_RUN: begin
                quo_next     = quo_shift;
                rem_next     = new_rem;
                bit_cnt_next = DADDR_W'(bit_cnt_reg + DADDR_W'(1));
                if (bit_cnt_reg == DADDR_W'(VALUE_W - 1)) begin
                    dig_wr.wr_en = 1'b1;
                    dig_cnt_next = dig_wr.count;
                    rem_next     = '0;
                    if (quo_shift == '0) begin
                        dig_wr.done = 1'b1;
                        state_next  = DV_IDLE;
                    end
                end
            end
        endcase
    end

    assign busy = (state_reg != DV_IDLE);

endmodule

>>> sv/sitr_emit.sv
// Digit store and character emitter: sign, then digits most significant first.
module sitr_emit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sitr_pkg::sitr_dig_wr_t   dig_wr,
    input  logic                     neg,
    input  sitr_pkg::sitr_syms_t     syms,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast,
    output logic                     busy
);
    import sitr_pkg::*;

    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    emit_state_t        state_reg, state_next;
    logic [DADDR_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (dig_wr.wr_en) begin
            digit_mem[dig_wr.addr] <= dig_wr.digit;
        end
        rd_data_reg <= digit_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        m_tvalid   = 1'b0;
        m_tdata    = syms[rd_data_reg];
        m_tlast    = 1'b0;

        unique case (state_reg)
            EM_IDLE: begin
                if (dig_wr.done) begin
                    idx_next   = DADDR_W'(dig_wr.count - DCNT_W'(1));
                    state_next = neg ? EM_SIGN : EM_READ;
                end
            end
            EM_SIGN: begin
                m_tvalid = 1'b1;
                m_tdata  = MINUS_CODE;
                if (m_tready) begin
                    state_next = EM_READ;
                end
            end
            EM_READ: begin
                state_next = EM_SHOW;
            end
            EM_SHOW: begin
                m_tvalid = 1'b1;
                m_tlast  = (idx_reg == '0);
                if (m_tready) begin
                    if (idx_reg == '0) begin
                        state_next = EM_IDLE;
                    end else begin
                        idx_next   = DADDR_W'(idx_reg - DADDR_W'(1));
                        state_next = EM_READ;
                    end
                end
            end
        endcase
    end

    assign busy = (state_reg != EM_IDLE);

endmodule

>>> sv/signed_int_to_radix_text.sv
// Converts a signed 32-bit value into text in a radix set by a configured
// alphabet of 2 to 16 byte symbols. One value is in flight at a time: s_tready
// is high only while the block is idle. A value passes through the bit-serial
// divider (one quotient bit per cycle), which writes its 1 to 32 digits into
// the digit store; the characters then go out most significant first, after a
// minus sign for a negative value. The block is back to idle with s_tready high
// in the cycle after the last character; output stalls delay that.
// With an invalid alphabet the value is dropped and no characters appear.
// After a configuration write s_tready stays low while the alphabet check
// settles.
module signed_int_to_radix_text (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [31:0]                  s_tdata,   // [31:0] value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] character
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [sitr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sitr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sitr_pkg::*;

    `include "assert_macros.svh"

    logic [RADIX_W-1:0] radix;
    sitr_syms_t         syms;
    logic               alpha_ok;
    logic               cfg_busy;
    logic               div_busy;
    logic               emit_busy;
    logic               start;
    logic [VALUE_W-1:0] magnitude;
    logic               neg_reg;
    sitr_dig_wr_t       dig_wr;

    sitr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .radix     (radix),
        .syms      (syms),
        .alpha_ok  (alpha_ok),
        .busy      (cfg_busy)
    );

    assign s_tready  = !div_busy && !emit_busy && !cfg_busy;
    assign start     = s_tvalid && s_tready && alpha_ok;
    // two's complement negate; the most negative value maps to 2^31
    assign magnitude = s_tdata[VALUE_W-1] ? VALUE_W'(-s_tdata) : VALUE_W'(s_tdata);

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= s_tdata[VALUE_W-1];
        end
    end

    sitr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .magnitude (magnitude),
        .radix     (radix),
        .busy      (div_busy),
        .dig_wr    (dig_wr)
    );

    sitr_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dig_wr   (dig_wr),
        .neg      (neg_reg),
        .syms     (syms),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .busy     (emit_busy)
    );

    `ASSERT_NEVER(a_in_out_exclusive, s_tready && m_tvalid)
    `ASSERT_AT_CLK(a_bad_alpha_drops, s_tvalid && s_tready && !alpha_ok |=> s_tready)
    `ASSERT_AT_CLK(a_last_not_sign, m_tvalid && m_tlast |-> m_tdata != MINUS_CODE)

endmodule
